/* sv/stt_pkg.sv */
// Shared types, constants and character class functions for the source text tokenizer.
package stt_pkg;

  // Result kinds as reported on the output channel.
  localparam logic [2:0] KIND_IDENT  = 3'd0;
  localparam logic [2:0] KIND_NUMBER = 3'd1;
  localparam logic [2:0] KIND_STRING = 3'd2;
  localparam logic [2:0] KIND_SINGLE = 3'd3;
  localparam logic [2:0] KIND_UNTERM = 3'd4;

  // Kinds of the token that is still open.
  localparam logic [1:0] OPEN_IDENT  = 2'd0;
  localparam logic [1:0] OPEN_NUMBER = 2'd1;
  localparam logic [1:0] OPEN_STRING = 2'd2;

  // Character codes with a special meaning.
  localparam logic [7:0] CHAR_QUOTE  = 8'h22;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_UNDER  = 8'h5F;

  // Result queue geometry.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // One result item.
  typedef struct packed {
    logic [2:0]  token_kind;
    logic [23:0] start_index;
    logic [15:0] token_length;
    logic [19:0] start_line;
    logic [15:0] start_column;
    logic        last_of_run;
  } token_t;

  // Tokenizer state carried from one character to the next.
  typedef struct packed {
    logic [1:0]  open_kind;
    logic        token_open;
    logic        after_backslash;
    logic [23:0] open_start_index;
    logic [15:0] open_length;
    logic [19:0] open_line;
    logic [15:0] open_column;
    logic [19:0] line_count;
    logic [15:0] column_count;
    logic [23:0] byte_index;
  } state_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c inside {[8'h09 : 8'h0D]});
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h41 : 8'h5A], [8'h61 : 8'h7A]};
  endfunction

  function automatic logic is_num_char(input logic [7:0] c);
    return c inside {[8'h30 : 8'h39]};
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_num_char(c) || (c == CHAR_UNDER);
  endfunction

endpackage

/* sv/source_text_tokenizer_unit.sv */
// Top level of the source text tokenizer: state register, step logic and result queue.
//
// Usage: one source byte is offered per request on the input channel
// (char_code_i, end_mark_i with in_valid_i); the block drives in_stall_o.
// Whitespace is skipped and every token is reported as one request on the
// output channel with its kind, start index, length, start line and column.
// A request with end_mark_i set flushes the open token, if any.
// Each input request gives zero, one or two result requests; last_of_run_o
// marks the last result of one input request.
// Results are registered in the result queue. Throughput: one input request per
// cycle when in_stall_o is low; the output side moves one result per cycle when
// out_stall_i is low, so a run of two-result characters is paced by the output port.
// The input stalls while the four-entry result queue has fewer than two free
// slots; a stalled output keeps its request steady and fills the queue.
// Reset clears the tokenizer state, the position counters and the queue.
module source_text_tokenizer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_mark_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  token_kind_o,
  output logic [23:0] start_index_o,
  output logic [15:0] token_length_o,
  output logic [19:0] start_line_o,
  output logic [15:0] start_column_o,
  output logic        last_of_run_o
);
  import stt_pkg::*;

  state_t     state_q, state_d;
  token_t     res0, res1, head;
  logic [1:0] res_cnt;
  logic [1:0] push_cnt;
  logic       in_acc;
  logic       pop;
  logic       room2;
  logic       not_empty;

  assign in_stall_o = !room2;
  assign in_acc     = in_valid_i && room2;
  assign pop        = not_empty && !out_stall_i;
  assign push_cnt   = in_acc ? res_cnt : 2'd0;

  // Per-character step logic.
  stt_step u_step (
    .state_i     (state_q),
    .char_code_i (char_code_i),
    .end_mark_i  (end_mark_i),
    .state_o     (state_d),
    .res0_o      (res0),
    .res1_o      (res1),
    .res_cnt_o   (res_cnt)
  );

  // Tokenizer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  // Result queue toward the output channel.
  stt_res_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push0_i     (res0),
    .push1_i     (res1),
    .pop_i       (pop),
    .head_o      (head),
    .not_empty_o (not_empty),
    .room2_o     (room2)
  );

  assign out_valid_o    = not_empty;
  assign token_kind_o   = head.token_kind;
  assign start_index_o  = head.start_index;
  assign token_length_o = head.token_length;
  assign start_line_o   = head.start_line;
  assign start_column_o = head.start_column;
  assign last_of_run_o  = head.last_of_run;

  // An end request with no open token produces no result.
  a_end_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && end_mark_i && !state_q.token_open) |-> (res_cnt == 2'd0))
    else $error("end request without open token produced a result");

  // An open token always has a nonzero length.
  a_open_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.token_open |-> (state_q.open_length != 16'd0))
    else $error("open token with zero length");

  // A character request advances the byte index until it saturates.
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !end_mark_i && !(&state_q.byte_index)) |=>
    (state_q.byte_index == $past(state_q.byte_index) + 24'd1))
    else $error("byte index did not advance");

  // A stalled output request stays valid and keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(head)))
    else $error("stalled output request changed");

endmodule

/* sv/stt_step.sv */
// Combinational step logic: classifies one character, updates the state and forms results.
module stt_step (
  input  stt_pkg::state_t state_i,
  input  logic [7:0]      char_code_i,
  input  logic            end_mark_i,
  output stt_pkg::state_t state_o,
  output stt_pkg::token_t res0_o,
  output stt_pkg::token_t res1_o,
  output logic [1:0]      res_cnt_o
);
  import stt_pkg::*;

  logic        emit;
  logic        single;
  logic        consumed;
  logic [2:0]  emit_kind;
  logic [15:0] len_inc;
  logic        grows;
  token_t      closed_tok;
  token_t      single_tok;

  // Saturating length increment and class test for the open token.
  assign len_inc = (&state_i.open_length) ? state_i.open_length
                                          : state_i.open_length + 16'd1;
  assign grows = (state_i.open_kind == OPEN_IDENT) ? is_word(char_code_i)
                                                   : is_num_char(char_code_i);

  // Main state update.
  always_comb begin
    state_o   = state_i;
    emit      = 1'b0;
    single    = 1'b0;
    consumed  = 1'b0;
    emit_kind = {1'b0, state_i.open_kind};
    if (end_mark_i) begin
      // Flush the open token; an open string is reported as unterminated.
      if (state_i.token_open) begin
        emit = 1'b1;
        if (state_i.open_kind == OPEN_STRING) begin
          emit_kind = KIND_UNTERM;
        end
        state_o.token_open      = 1'b0;
        state_o.after_backslash = 1'b0;
      end
    end else begin
      if (state_i.token_open) begin
        if (state_i.open_kind == OPEN_STRING) begin
          state_o.open_length = len_inc;
          consumed = 1'b1;
          if ((char_code_i == CHAR_QUOTE) && !state_i.after_backslash) begin
            emit = 1'b1;
            state_o.token_open      = 1'b0;
            state_o.after_backslash = 1'b0;
          end else begin
            state_o.after_backslash = (char_code_i == CHAR_BSLASH);
          end
        end else if (grows) begin
          state_o.open_length = len_inc;
          consumed = 1'b1;
        end else begin
          emit = 1'b1;
          state_o.token_open      = 1'b0;
          state_o.after_backslash = 1'b0;
        end
      end

      // Start a new token or report a single character.
      if (!consumed && !is_space(char_code_i)) begin
        if (is_alpha(char_code_i) || is_num_char(char_code_i) ||
            (char_code_i == CHAR_QUOTE)) begin
          state_o.token_open       = 1'b1;
          state_o.after_backslash  = 1'b0;
          state_o.open_start_index = state_i.byte_index;
          state_o.open_length      = 16'd1;
          state_o.open_line        = state_i.line_count;
          state_o.open_column      = state_i.column_count;
          if (is_alpha(char_code_i)) begin
            state_o.open_kind = OPEN_IDENT;
          end else if (is_num_char(char_code_i)) begin
            state_o.open_kind = OPEN_NUMBER;
          end else begin
            state_o.open_kind = OPEN_STRING;
          end
        end else begin
          single = 1'b1;
        end
      end

      // Position counters move on every character.
      if (!(&state_i.byte_index)) begin
        state_o.byte_index = state_i.byte_index + 24'd1;
      end
      if ((char_code_i == CHAR_LF) || (char_code_i == CHAR_CR)) begin
        state_o.column_count = '0;
      end else if (!(&state_i.column_count)) begin
        state_o.column_count = state_i.column_count + 16'd1;
      end
      if ((char_code_i == CHAR_LF) && !(&state_i.line_count)) begin
        state_o.line_count = state_i.line_count + 20'd1;
      end
    end
  end

  // Result formation: the closed token comes before a single character.
  always_comb begin
    closed_tok.token_kind   = emit_kind;
    closed_tok.start_index  = state_i.open_start_index;
    closed_tok.token_length = state_i.open_length;
    if (!end_mark_i && (state_i.open_kind == OPEN_STRING)) begin
      closed_tok.token_length = len_inc;
    end
    closed_tok.start_line   = state_i.open_line;
    closed_tok.start_column = state_i.open_column;
    closed_tok.last_of_run  = !single;

    single_tok.token_kind   = KIND_SINGLE;
    single_tok.start_index  = state_i.byte_index;
    single_tok.token_length = 16'd1;
    single_tok.start_line   = state_i.line_count;
    single_tok.start_column = state_i.column_count;
    single_tok.last_of_run  = 1'b1;
  end

  assign res0_o    = emit ? closed_tok : single_tok;
  assign res1_o    = single_tok;
  assign res_cnt_o = {1'b0, emit} + {1'b0, single};

endmodule

/* sv/stt_res_queue.sv */
// Result queue: takes up to two results per cycle, gives one per cycle on pop.
module stt_res_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [1:0]      push_cnt_i,
  input  stt_pkg::token_t push0_i,
  input  stt_pkg::token_t push1_i,
  input  logic            pop_i,
  output stt_pkg::token_t head_o,
  output logic            not_empty_o,
  output logic            room2_o
);
  import stt_pkg::*;

  token_t                   mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0]   count_q, count_d;
  logic [QUEUE_PTR_W-1:0]   wr_ptr_next;

  assign wr_ptr_next = wr_ptr_q + QUEUE_PTR_W'(1);
  assign head_o      = mem_q[rd_ptr_q];
  assign not_empty_o = (count_q != '0);
  assign room2_o     = (count_q <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q + QUEUE_PTR_W'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + QUEUE_PTR_W'(pop_i);
    count_d  = count_q + QUEUE_CNT_W'(push_cnt_i) - QUEUE_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage; the second result goes to the slot after the first.
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_next] <= push1_i;
    end
  end

endmodule
